### sv/tets_pkg.sv
// Shared types, constants and codes for the timed event track sequencer.
`timescale 1ns / 1ps

package tets_pkg;

	// pool geometry
	localparam int NUM_TRACKS      = 4;
	localparam int BEATS_PER_TRACK = 16;
	localparam int TRK_W  = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
	localparam int TCNT_W = $clog2(NUM_TRACKS + 1);
	localparam int BEAT_W = (BEATS_PER_TRACK > 1) ? $clog2(BEATS_PER_TRACK) : 1;
	localparam int CNT_W  = $clog2(BEATS_PER_TRACK + 1);
	localparam int ADDR_W = TRK_W + BEAT_W;
	localparam int DEPTH  = 2 ** ADDR_W;
	localparam int TIME_W = 20;

	localparam logic [TIME_W-1:0] CLOCK_MAX = '1;
	localparam logic [31:0]       NO_SERIAL = 32'hFFFF_FFFF;

	// actions
	localparam logic [2:0] ACT_BEGIN        = 3'd0;
	localparam logic [2:0] ACT_ADD          = 3'd1;
	localparam logic [2:0] ACT_SET_UNSCALED = 3'd2;
	localparam logic [2:0] ACT_PLAY         = 3'd3;
	localparam logic [2:0] ACT_STOP         = 3'd4;
	localparam logic [2:0] ACT_TICK         = 3'd5;

	// reply status
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_IGNORED   = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_EXHAUSTED = 3'd3;
	localparam logic [2:0] ST_RECYCLED  = 3'd4;

	// result kind
	localparam logic KIND_REPLY = 1'b0;
	localparam logic KIND_BEAT  = 1'b1;

	typedef struct packed {
		logic [2:0]         action;
		logic [1:0]         sequence_slot;
		logic signed [19:0] beat_time;
		logic [15:0]        beat_tag;
		logic               unscaled_mode;
		logic [15:0]        scaled_delta;
		logic [15:0]        raw_delta;
	} cmd_t;

	typedef struct packed {
		logic        result_kind;
		logic [2:0]  status;
		logic [1:0]  result_slot;
		logic [15:0] fired_tag;
		logic        last_result;
	} res_t;

	typedef struct packed {
		logic [TIME_W-1:0] beat_time;
		logic              fired;
		logic [15:0]       tag;
	} beat_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		beat_t             wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic              in_use;
		logic              playing;
		logic              unscaled;
		logic [TIME_W-1:0] clock;
		logic [TIME_W-1:0] end_time;
		logic [CNT_W-1:0]  cnt;
		logic [31:0]       serial;
	} track_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_BEGIN_SCAN,
		S_REPLY,
		S_SR_KEY,
		S_SR_KEYW,
		S_SR_CMP,
		S_SR_PUT,
		S_TK_TRK,
		S_TK_RD,
		S_TK_EV,
		S_TK_END,
		S_TK_FLUSH
	} state_t;

	function automatic logic [ADDR_W-1:0] beat_addr(input logic [TRK_W-1:0] trk,
			input logic [BEAT_W-1:0] idx);
		return {trk, idx};
	endfunction

endpackage

### sv/timed_event_track_sequencer.sv
// Top level: command intake, sequencer engine and result output register.
//
//  channel | direction | handshake            | payload
//  cmd     | in        | cmd_valid/cmd_stall  | tets_pkg::cmd_t
//  res     | out       | res_valid/res_stall  | tets_pkg::res_t
//
// One request at a time. Add, set and stop go straight to their reply; so does
// begin, unless every slot is in use: then it scans every track for the playing
// track with the oldest serial. Play runs an insertion sort through the beat
// memory, moving each beat down past earlier beats that are later. Tick visits
// every track, reads each playing track's beats up to the first one not yet due,
// then flushes the held-back beat. Reset clears all track state; beat memory is not cleared.
// A stalled result holds the engine only when it has another result to push.
`timescale 1ns / 1ps

module timed_event_track_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  tets_pkg::cmd_t  cmd,
	output logic            res_valid,
	input  logic            res_stall,
	output tets_pkg::res_t  res
);

	logic           idle, push, room;
	tets_pkg::res_t push_data, res_q;
	logic           res_valid_q;

	assign cmd_stall = !idle;
	assign room      = !res_valid_q || !res_stall;

	tets_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_go   (cmd_valid && !cmd_stall),
		.cmd      (cmd),
		.idle     (idle),
		.res_push (push),
		.res_d    (push_data),
		.res_room (room)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push && room) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && room) begin
			res_q <= push_data;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a taken request always keeps the engine busy for the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("engine idle right after taking a request");

	// status replies are single and carry no tag
	a_reply_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.result_kind == tets_pkg::KIND_REPLY)
		|-> res.last_result && (res.fired_tag == 16'd0))
		else $error("malformed status reply");

	// fired beats carry ok status
	a_beat_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.result_kind == tets_pkg::KIND_BEAT)
		|-> (res.status == tets_pkg::ST_OK))
		else $error("fired beat with nonzero status");

endmodule

### sv/tets_beat_ram.sv
// Beat store: one write port, one registered read port.
`timescale 1ns / 1ps

module tets_beat_ram (
	input  logic                clk,
	input  tets_pkg::ram_req_t  req,
	output tets_pkg::beat_t     rdata
);

	tets_pkg::beat_t mem [tets_pkg::DEPTH];
	tets_pkg::beat_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/tets_engine.sv
// Command sequencer: track state, begin scan, insertion sort and tick scan.
`timescale 1ns / 1ps

module tets_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_go,
	input  tets_pkg::cmd_t  cmd,
	output logic            idle,
	output logic            res_push,
	output tets_pkg::res_t  res_d,
	input  logic            res_room
);

	tets_pkg::state_t  state_q, state_d;
	tets_pkg::cmd_t    cmd_q, cmd_d;
	tets_pkg::track_t  trk_q [tets_pkg::NUM_TRACKS];
	tets_pkg::track_t  trk_d [tets_pkg::NUM_TRACKS];
	logic [31:0]       nser_q, nser_d;
	logic [tets_pkg::TCNT_W-1:0] t_q, t_d;
	logic [tets_pkg::CNT_W-1:0]  i_q, i_d, j_q, j_d;
	tets_pkg::beat_t   key_q, key_d;
	logic [tets_pkg::TIME_W-1:0] c_q, c_d;
	logic              all_q, all_d;
	logic              pend_v_q, pend_v_d;
	tets_pkg::res_t    pend_q, pend_d, rep_q, rep_d;
	logic [31:0]       best_q, best_d;
	logic [tets_pkg::TRK_W-1:0] pick_q, pick_d;
	logic              pick_v_q, pick_v_d;

	tets_pkg::ram_req_t ram;
	tets_pkg::beat_t    rdata;

	logic [tets_pkg::TRK_W-1:0]  sidx, tt, free_idx;
	logic                        any_free, slot_ok;
	logic [tets_pkg::TIME_W-1:0] add_time, new_clk;
	logic [tets_pkg::TIME_W:0]   clk_sum;
	logic [15:0]                 delta;
	tets_pkg::track_t            fresh;

	tets_beat_ram u_ram (
		.clk   (clk),
		.req   (ram),
		.rdata (rdata)
	);

	assign idle     = (state_q == tets_pkg::S_IDLE);
	assign sidx     = tets_pkg::TRK_W'(cmd_q.sequence_slot);
	assign slot_ok  = (int'(cmd_q.sequence_slot) < tets_pkg::NUM_TRACKS);
	assign tt       = tets_pkg::TRK_W'(t_q);
	assign add_time = cmd_q.beat_time[19] ? '0 : $unsigned(cmd_q.beat_time);

	// saturating clock advance for the track under scan
	always_comb begin
		delta   = trk_q[tt].unscaled ? cmd_q.raw_delta : cmd_q.scaled_delta;
		clk_sum = {1'b0, trk_q[tt].clock} + (tets_pkg::TIME_W + 1)'(delta);
		new_clk = clk_sum[tets_pkg::TIME_W] ? tets_pkg::CLOCK_MAX
			: clk_sum[tets_pkg::TIME_W-1:0];
	end

	// lowest free slot
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int k = tets_pkg::NUM_TRACKS - 1; k >= 0; k--) begin
			if (!trk_q[k].in_use) begin
				any_free = 1'b1;
				free_idx = tets_pkg::TRK_W'(k);
			end
		end
	end

	always_comb begin
		fresh        = '0;
		fresh.in_use = 1'b1;
	end

	// next state, memory requests and result pushes
	always_comb begin
		state_d  = state_q;
		cmd_d    = cmd_q;
		trk_d    = trk_q;
		nser_d   = nser_q;
		t_d      = t_q;
		i_d      = i_q;
		j_d      = j_q;
		key_d    = key_q;
		c_d      = c_q;
		all_d    = all_q;
		pend_v_d = pend_v_q;
		pend_d   = pend_q;
		rep_d    = rep_q;
		best_d   = best_q;
		pick_d   = pick_q;
		pick_v_d = pick_v_q;
		ram      = '0;
		res_push = 1'b0;
		res_d    = rep_q;

		case (state_q)
			tets_pkg::S_IDLE: begin
				if (cmd_go) begin
					cmd_d   = cmd;
					state_d = tets_pkg::S_DECODE;
				end
			end

			tets_pkg::S_DECODE: begin
				rep_d.result_kind = tets_pkg::KIND_REPLY;
				rep_d.status      = tets_pkg::ST_OK;
				rep_d.result_slot = cmd_q.sequence_slot;
				rep_d.fired_tag   = '0;
				rep_d.last_result = 1'b1;
				state_d = tets_pkg::S_REPLY;
				case (cmd_q.action)
					tets_pkg::ACT_BEGIN: begin
						if (any_free) begin
							trk_d[free_idx]   = fresh;
							rep_d.result_slot = 2'(free_idx);
						end else begin
							t_d      = '0;
							best_d   = tets_pkg::NO_SERIAL;
							pick_d   = '0;
							pick_v_d = 1'b0;
							state_d  = tets_pkg::S_BEGIN_SCAN;
						end
					end
					tets_pkg::ACT_ADD, tets_pkg::ACT_SET_UNSCALED,
					tets_pkg::ACT_PLAY, tets_pkg::ACT_STOP: begin
						if (!slot_ok) begin
							rep_d.status = tets_pkg::ST_IGNORED;
						end else if (cmd_q.action == tets_pkg::ACT_STOP) begin
							trk_d[sidx].playing = 1'b0;
							trk_d[sidx].in_use  = 1'b0;
						end else if (!trk_q[sidx].in_use) begin
							rep_d.status = tets_pkg::ST_IGNORED;
						end else if (cmd_q.action == tets_pkg::ACT_ADD) begin
							if (trk_q[sidx].playing) begin
								rep_d.status = tets_pkg::ST_IGNORED;
							end else if (int'(trk_q[sidx].cnt) >= tets_pkg::BEATS_PER_TRACK) begin
								rep_d.status = tets_pkg::ST_FULL;
							end else begin
								ram.we              = 1'b1;
								ram.waddr           = tets_pkg::beat_addr(sidx,
									tets_pkg::BEAT_W'(trk_q[sidx].cnt));
								ram.wdata.beat_time = add_time;
								ram.wdata.fired     = 1'b0;
								ram.wdata.tag       = cmd_q.beat_tag;
								trk_d[sidx].cnt = trk_q[sidx].cnt + tets_pkg::CNT_W'(1);
								if (add_time > trk_q[sidx].end_time) begin
									trk_d[sidx].end_time = add_time;
								end
							end
						end else if (cmd_q.action == tets_pkg::ACT_SET_UNSCALED) begin
							if (trk_q[sidx].playing) begin
								rep_d.status = tets_pkg::ST_IGNORED;
							end else begin
								trk_d[sidx].unscaled = cmd_q.unscaled_mode;
							end
						end else begin
							i_d     = tets_pkg::CNT_W'(1);
							state_d = tets_pkg::S_SR_KEY;
						end
					end
					tets_pkg::ACT_TICK: begin
						t_d      = '0;
						pend_v_d = 1'b0;
						state_d  = tets_pkg::S_TK_TRK;
					end
					default: begin
						rep_d.status      = tets_pkg::ST_IGNORED;
						rep_d.result_slot = '0;
					end
				endcase
			end

			// pool full: pick the playing track with the oldest serial
			tets_pkg::S_BEGIN_SCAN: begin
				if (t_q == tets_pkg::TCNT_W'(tets_pkg::NUM_TRACKS)) begin
					if (pick_v_q) begin
						trk_d[pick_q]     = fresh;
						rep_d.status      = tets_pkg::ST_RECYCLED;
						rep_d.result_slot = 2'(pick_q);
					end else begin
						rep_d.status      = tets_pkg::ST_EXHAUSTED;
						rep_d.result_slot = '0;
					end
					state_d = tets_pkg::S_REPLY;
				end else begin
					if (trk_q[tt].playing && (trk_q[tt].serial < best_q)) begin
						best_d   = trk_q[tt].serial;
						pick_d   = tt;
						pick_v_d = 1'b1;
					end
					t_d = t_q + tets_pkg::TCNT_W'(1);
				end
			end

			tets_pkg::S_REPLY: begin
				res_push = 1'b1;
				res_d    = rep_q;
				if (res_room) begin
					state_d = tets_pkg::S_IDLE;
				end
			end

			// insertion sort: fetch key i
			tets_pkg::S_SR_KEY: begin
				if (i_q >= trk_q[sidx].cnt) begin
					trk_d[sidx].clock   = '0;
					trk_d[sidx].playing = 1'b1;
					trk_d[sidx].serial  = nser_q;
					nser_d  = nser_q + 32'd1;
					state_d = tets_pkg::S_REPLY;
				end else begin
					ram.re    = 1'b1;
					ram.raddr = tets_pkg::beat_addr(sidx, tets_pkg::BEAT_W'(i_q));
					state_d   = tets_pkg::S_SR_KEYW;
				end
			end

			tets_pkg::S_SR_KEYW: begin
				key_d     = rdata;
				j_d       = i_q;
				ram.re    = 1'b1;
				ram.raddr = tets_pkg::beat_addr(sidx,
					tets_pkg::BEAT_W'(i_q - tets_pkg::CNT_W'(1)));
				state_d   = tets_pkg::S_SR_CMP;
			end

			// rdata holds entry j-1; shift it up while it is later than the key
			tets_pkg::S_SR_CMP: begin
				ram.we = 1'b1;
				ram.waddr = tets_pkg::beat_addr(sidx, tets_pkg::BEAT_W'(j_q));
				if (rdata.beat_time > key_q.beat_time) begin
					ram.wdata = rdata;
					j_d = j_q - tets_pkg::CNT_W'(1);
					if (j_q == tets_pkg::CNT_W'(1)) begin
						state_d = tets_pkg::S_SR_PUT;
					end else begin
						ram.re    = 1'b1;
						ram.raddr = tets_pkg::beat_addr(sidx,
							tets_pkg::BEAT_W'(j_q - tets_pkg::CNT_W'(2)));
					end
				end else begin
					ram.wdata = key_q;
					i_d       = i_q + tets_pkg::CNT_W'(1);
					state_d   = tets_pkg::S_SR_KEY;
				end
			end

			tets_pkg::S_SR_PUT: begin
				ram.we    = 1'b1;
				ram.waddr = tets_pkg::beat_addr(sidx, '0);
				ram.wdata = key_q;
				i_d       = i_q + tets_pkg::CNT_W'(1);
				state_d   = tets_pkg::S_SR_KEY;
			end

			// tick: advance one track
			tets_pkg::S_TK_TRK: begin
				if (t_q == tets_pkg::TCNT_W'(tets_pkg::NUM_TRACKS)) begin
					state_d = tets_pkg::S_TK_FLUSH;
				end else if (trk_q[tt].in_use && trk_q[tt].playing) begin
					trk_d[tt].clock = new_clk;
					c_d     = new_clk;
					j_d     = '0;
					all_d   = 1'b1;
					state_d = tets_pkg::S_TK_RD;
				end else begin
					t_d = t_q + tets_pkg::TCNT_W'(1);
				end
			end

			tets_pkg::S_TK_RD: begin
				if (j_q >= trk_q[tt].cnt) begin
					state_d = tets_pkg::S_TK_END;
				end else begin
					ram.re    = 1'b1;
					ram.raddr = tets_pkg::beat_addr(tt, tets_pkg::BEAT_W'(j_q));
					state_d   = tets_pkg::S_TK_EV;
				end
			end

			// one beat held back so the final one can carry last_result
			tets_pkg::S_TK_EV: begin
				if (rdata.fired) begin
					j_d     = j_q + tets_pkg::CNT_W'(1);
					state_d = tets_pkg::S_TK_RD;
				end else if (rdata.beat_time <= c_q) begin
					if (pend_v_q) begin
						res_push = 1'b1;
						res_d    = pend_q;
					end
					if (!pend_v_q || res_room) begin
						ram.we          = 1'b1;
						ram.waddr       = tets_pkg::beat_addr(tt, tets_pkg::BEAT_W'(j_q));
						ram.wdata       = rdata;
						ram.wdata.fired = 1'b1;
						pend_d.result_kind = tets_pkg::KIND_BEAT;
						pend_d.status      = tets_pkg::ST_OK;
						pend_d.result_slot = 2'(tt);
						pend_d.fired_tag   = rdata.tag;
						pend_d.last_result = 1'b0;
						pend_v_d = 1'b1;
						j_d      = j_q + tets_pkg::CNT_W'(1);
						state_d  = tets_pkg::S_TK_RD;
					end
				end else begin
					all_d   = 1'b0;
					state_d = tets_pkg::S_TK_END;
				end
			end

			tets_pkg::S_TK_END: begin
				if (all_q && (c_q >= trk_q[tt].end_time)) begin
					trk_d[tt].in_use  = 1'b0;
					trk_d[tt].playing = 1'b0;
				end
				t_d     = t_q + tets_pkg::TCNT_W'(1);
				state_d = tets_pkg::S_TK_TRK;
			end

			tets_pkg::S_TK_FLUSH: begin
				if (pend_v_q) begin
					res_push          = 1'b1;
					res_d             = pend_q;
					res_d.last_result = 1'b1;
					if (res_room) begin
						pend_v_d = 1'b0;
						state_d  = tets_pkg::S_IDLE;
					end
				end else begin
					state_d = tets_pkg::S_IDLE;
				end
			end

			default: state_d = tets_pkg::S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tets_pkg::S_IDLE;
			nser_q   <= 32'd1;
			pend_v_q <= 1'b0;
			for (int k = 0; k < tets_pkg::NUM_TRACKS; k++) begin
				trk_q[k] <= '0;
			end
		end else begin
			state_q  <= state_d;
			nser_q   <= nser_d;
			pend_v_q <= pend_v_d;
			trk_q    <= trk_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		t_q      <= t_d;
		i_q      <= i_d;
		j_q      <= j_d;
		key_q    <= key_d;
		c_q      <= c_d;
		all_q    <= all_d;
		pend_q   <= pend_d;
		rep_q    <= rep_d;
		best_q   <= best_d;
		pick_q   <= pick_d;
		pick_v_q <= pick_v_d;
	end

endmodule
